// ===== rtl/core/grid_idw_height_interpolator_core_assert.svh =====
// Assertion macros shared by the interpolator core RTL.
`ifndef GRID_IDW_HEIGHT_INTERPOLATOR_CORE_ASSERT_SVH
`define GRID_IDW_HEIGHT_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define GIDW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define GIDW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gidw_pkg.sv =====
// Package with widths, codes and divider request types of the interpolator core.
`timescale 1ns / 1ps
`default_nettype none

package gidw_pkg;

  localparam int unsigned CFG_W    = 11;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned HGT_W    = 16;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned CIDX_W   = 5;
  localparam int unsigned FRAC_W   = 8;

  // Controls per grid side; the table holds GROUP * GROUP heights.
  localparam int unsigned GROUP    = 5;

  // The grid step is (width * STEP_RECIP) >> STEP_SHIFT, which equals
  // width / GROUP for every width below 2730.
  localparam int unsigned STEP_SHIFT = 13;
  localparam int unsigned STEP_RECIP = (2**STEP_SHIFT + GROUP - 1) / GROUP;

  // Shared divider: remainder/divisor width and quotient shift width.
  localparam int unsigned REM_W    = 43;
  localparam int unsigned QUO_W    = 41;
  localparam int unsigned CNT_W    = 6;

  localparam int unsigned D2_W     = 23;
  localparam int unsigned NUM_W    = 59;
  localparam int unsigned WLO_W    = 20;
  localparam int unsigned MUL_A_W  = 21;
  localparam int unsigned MUL_B_W  = 16;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned NUM_LO_W = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd320;

  // Configuration register indexes.
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_LENGTH = 1'b1;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem_init;
    logic [QUO_W-1:0] lo;
    logic [REM_W-1:0] divisor;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/gidw_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
`timescale 1ns / 1ps
`default_nettype none

interface gidw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [gidw_pkg::CIDX_W-1:0]   control_index;
  logic [gidw_pkg::HGT_W-1:0]    control_height;
  logic [gidw_pkg::POS_W-1:0]    pos_x;
  logic [gidw_pkg::POS_W-1:0]    pos_y;

  modport source (output valid, operation, control_index, control_height, pos_x, pos_y,
                  input ready);
  modport sink (input valid, operation, control_index, control_height, pos_x, pos_y,
                output ready);
endinterface

interface gidw_out_if;
  logic                          valid;
  logic                          ready;
  logic [gidw_pkg::OUT_W-1:0]    height_out;

  modport source (output valid, height_out, input ready);
  modport sink (input valid, height_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gidw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gidw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 25
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/gidw_div.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_idw_height_interpolator_core_assert.svh"

module gidw_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gidw_pkg::div_req_t  req_i,
  output gidw_pkg::div_rsp_t       rsp_o
);

  localparam int unsigned REM_W = gidw_pkg::REM_W;
  localparam int unsigned QUO_W = gidw_pkg::QUO_W;
  localparam int unsigned CNT_W = gidw_pkg::CNT_W;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] divisor_q;
  logic [QUO_W-1:0] shf_q;

  logic [REM_W:0]   trial;
  logic [REM_W+1:0] diff;
  logic             qbit;

  // The remainder stays below the divisor, so the trial value fits one extra bit.
  assign trial = {rem_q, shf_q[QUO_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_q};
  assign qbit  = ~diff[REM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.count;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= req_i.rem_init;
      divisor_q <= req_i.divisor;
      shf_q     <= req_i.lo;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
      shf_q <= {shf_q[QUO_W-2:0], qbit};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = shf_q;

  `GIDW_ASSERT_NOW(a_div_no_restart, req_i.start, !busy_q, "divider restarted while busy")
  `GIDW_ASSERT_NOW(a_div_rem_bound, busy_q, rem_q < divisor_q, "remainder reached divisor")
  `GIDW_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q, "done held for more than one cycle")

endmodule

`default_nettype wire

// ===== rtl/core/grid_idw_height_interpolator_core.sv =====
// Top level of the grid inverse-distance-weighted height interpolator core.
//
// Usage: input items arrive on in_i, a valid/ready channel. A load item
// (operation = load) writes control_height into the control table entry
// control_index; it produces no result. A query item
// returns one result on out_o: the inverse-squared-distance weighted mean of
// the four control heights around (pos_x, pos_y), in hundredths with eight
// fraction bits, or the corner height itself when the point hits a corner.
// The shared divider produces one quotient bit per cycle: up to 10 bits per
// bracket search, 41 bits per corner weight and 24 for the normalization;
// the grid step is one reciprocal multiply. The input is ready only while the
// sequencer is idle, so a query blocks further items until it completes.
// A finished result sits in the output register; the block takes the next
// item while the receiver stalls, and only a second result waits for the
// first transfer on out_o. Configuration writes on cfg_we_i are taken at any
// time and must only happen while the block is idle. Reset sets grid width
// and length to 320 and clears all control state; the control table itself
// is not cleared and holds unknown heights until they are loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_idw_height_interpolator_core_assert.svh"

module grid_idw_height_interpolator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [gidw_pkg::CFG_W-1:0]  cfg_data_i,
  gidw_in_if.sink                          in_i,
  gidw_out_if.source                       out_o
);

  localparam int unsigned GROUP    = gidw_pkg::GROUP;
  localparam int unsigned CFG_W    = gidw_pkg::CFG_W;
  localparam int unsigned POS_W    = gidw_pkg::POS_W;
  localparam int unsigned HGT_W    = gidw_pkg::HGT_W;
  localparam int unsigned OUT_W    = gidw_pkg::OUT_W;
  localparam int unsigned FRAC_W   = gidw_pkg::FRAC_W;
  localparam int unsigned REM_W    = gidw_pkg::REM_W;
  localparam int unsigned QUO_W    = gidw_pkg::QUO_W;
  localparam int unsigned CNT_W    = gidw_pkg::CNT_W;
  localparam int unsigned D2_W     = gidw_pkg::D2_W;
  localparam int unsigned NUM_W    = gidw_pkg::NUM_W;
  localparam int unsigned WLO_W    = gidw_pkg::WLO_W;
  localparam int unsigned MUL_A_W  = gidw_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W  = gidw_pkg::MUL_B_W;
  localparam int unsigned MUL_P_W  = gidw_pkg::MUL_P_W;
  localparam int unsigned NUM_LO_W = gidw_pkg::NUM_LO_W;
  localparam int unsigned STEP_SHIFT = gidw_pkg::STEP_SHIFT;
  localparam int unsigned STEP_RECIP = gidw_pkg::STEP_RECIP;

  localparam int unsigned TBL_DEPTH = GROUP * GROUP;
  localparam int unsigned ADDR_W    = $clog2(TBL_DEPTH);
  localparam int unsigned IDX_W     = $clog2(GROUP);
  localparam logic [IDX_W-1:0] LOW_MAX = IDX_W'(GROUP - 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_STEP, ST_BRK, ST_BRKW, ST_CORN, ST_CX, ST_CY, ST_DX2,
    ST_DY2, ST_WDIV, ST_MH, ST_ML, ST_ACC, ST_FIN, ST_FDIV, ST_DONE
  } state_e;

  // Configuration registers.
  logic [CFG_W-1:0] wid_q, len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= gidw_pkg::CFG_RESET;
      len_q <= gidw_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gidw_pkg::CFG_GRID_WIDTH:  wid_q <= cfg_data_i;
        gidw_pkg::CFG_GRID_LENGTH: len_q <= cfg_data_i;
        default:                   wid_q <= wid_q;
      endcase
    end
  end

  // Control state and registered outputs.
  state_e           state_q, state_d;
  logic             axis_q, axis_d;
  logic [1:0]       k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  // Datapath registers.
  logic [POS_W-1:0]   x_q, x_d, y_q, y_d;
  logic [CFG_W-1:0]   step_q, step_d;
  logic [IDX_W-1:0]   c0_q, c0_d, r0_q, r0_d;
  logic [CFG_W-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic [D2_W-1:0]    d2_q, d2_d;
  logic [QUO_W-1:0]   w_q, w_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [REM_W-1:0]   den_q, den_d;
  logic [OUT_W-1:0]   res_q, res_d;
  logic [MUL_P_W-1:0] prod_q;

  // Shared multiplier operands, chosen by the sequencer.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  gidw_pkg::div_req_t div_req;
  gidw_pkg::div_rsp_t div_rsp;

  // Control table.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [HGT_W-1:0]  hv;
  logic [7:0]        cidx_ext;

  // Bracket search for the axis being worked on.
  logic [CFG_W:0]     two;
  logic [CFG_W-1:0]   extent;
  logic [POS_W-1:0]   pos;
  logic [CFG_W:0]     ext_minus;
  logic               pos_low, pos_high;
  logic [POS_W-1:0]   brk_q;
  logic [IDX_W-1:0]   brk_sat;

  // Corner being evaluated.
  logic [IDX_W-1:0]   col, row;
  logic [D2_W-1:0]    d2_sum;

  // Grid step taken from the reciprocal product.
  logic [CFG_W-1:0]   step_raw;

  function automatic logic [CFG_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [CFG_W-1:0] b);
    logic [CFG_W-1:0] ae;
    ae = CFG_W'(a);
    return (ae >= b) ? (ae - b) : (b - ae);
  endfunction

  assign two       = {step_q, 1'b0};
  assign extent    = axis_q ? len_q : wid_q;
  assign pos       = axis_q ? y_q : x_q;
  assign ext_minus = {1'b0, extent} - two;
  assign pos_low   = (CFG_W'(pos) < two[CFG_W-1:0]) || two[CFG_W];
  // Either the extent is below two steps or the point lies past extent minus two steps.
  assign pos_high  = ({1'b0, extent} < two) || ((CFG_W + 1)'(pos) > ext_minus);
  assign brk_q     = div_rsp.quotient[POS_W-1:0];
  assign brk_sat   = (brk_q > POS_W'(GROUP - 2)) ? LOW_MAX : brk_q[IDX_W-1:0];
  assign step_raw  = prod_q[STEP_SHIFT +: CFG_W];

  assign col       = c0_q + IDX_W'(k_q[1]);
  assign row       = r0_q + IDX_W'(k_q[0]);
  assign ram_raddr = ADDR_W'(col) + ADDR_W'(row) * ADDR_W'(GROUP);
  assign d2_sum    = d2_q + prod_q[D2_W-1:0];

  assign cidx_ext  = 8'(in_i.control_index);
  assign ram_waddr = cidx_ext[ADDR_W-1:0];
  assign ram_we    = (state_q == ST_IDLE) && in_i.valid && (in_i.operation == gidw_pkg::OP_LOAD)
                     && (32'(in_i.control_index) < 32'(TBL_DEPTH));

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.height_out = out_data_q;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    x_d         = x_q;
    y_d         = y_q;
    step_d      = step_q;
    c0_d        = c0_q;
    r0_d        = r0_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    d2_d        = d2_q;
    w_d         = w_q;
    num_d       = num_q;
    den_d       = den_q;
    res_d       = res_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_i.operation == gidw_pkg::OP_QUERY) begin
          // Grid step is the width times a scaled reciprocal of the group count.
          x_d     = in_i.pos_x;
          y_d     = in_i.pos_y;
          mul_a   = MUL_A_W'(wid_q);
          mul_b   = MUL_B_W'(STEP_RECIP);
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        step_d  = (step_raw == '0) ? CFG_W'(1) : step_raw;
        axis_d  = 1'b0;
        state_d = ST_BRK;
      end
      ST_BRK: begin
        if (pos_low || pos_high) begin
          if (!axis_q) begin
            c0_d   = pos_low ? '0 : LOW_MAX;
            axis_d = 1'b1;
          end else begin
            r0_d    = pos_low ? '0 : LOW_MAX;
            k_d     = '0;
            num_d   = '0;
            den_d   = '0;
            state_d = ST_CORN;
          end
        end else begin
          div_req.start   = 1'b1;
          div_req.lo      = {pos, {(QUO_W - POS_W){1'b0}}};
          div_req.divisor = REM_W'(step_q);
          div_req.count   = CNT_W'(POS_W);
          state_d         = ST_BRKW;
        end
      end
      ST_BRKW: begin
        if (div_rsp.done) begin
          if (!axis_q) begin
            c0_d    = brk_sat;
            axis_d  = 1'b1;
            state_d = ST_BRK;
          end else begin
            r0_d    = brk_sat;
            k_d     = '0;
            num_d   = '0;
            den_d   = '0;
            state_d = ST_CORN;
          end
        end
      end
      ST_CORN: begin
        mul_a   = MUL_A_W'(col);
        mul_b   = MUL_B_W'(step_q);
        state_d = ST_CX;
      end
      ST_CX: begin
        dx_d    = abs_diff(x_q, prod_q[CFG_W-1:0]);
        mul_a   = MUL_A_W'(row);
        mul_b   = MUL_B_W'(step_q);
        state_d = ST_CY;
      end
      ST_CY: begin
        dy_d    = abs_diff(y_q, prod_q[CFG_W-1:0]);
        mul_a   = MUL_A_W'(dx_q);
        mul_b   = MUL_B_W'(dx_q);
        state_d = ST_DX2;
      end
      ST_DX2: begin
        d2_d    = prod_q[D2_W-1:0];
        mul_a   = MUL_A_W'(dy_q);
        mul_b   = MUL_B_W'(dy_q);
        state_d = ST_DY2;
      end
      ST_DY2: begin
        if (d2_sum == '0) begin
          // The point sits on this corner: its height is the answer.
          res_d   = {hv, {FRAC_W{1'b0}}};
          state_d = ST_DONE;
        end else begin
          div_req.start   = 1'b1;
          div_req.lo      = {1'b1, {(QUO_W - 1){1'b0}}};
          div_req.divisor = REM_W'(d2_sum);
          div_req.count   = CNT_W'(QUO_W);
          state_d         = ST_WDIV;
        end
      end
      ST_WDIV: begin
        if (div_rsp.done) begin
          w_d     = div_rsp.quotient;
          den_d   = den_q + REM_W'(div_rsp.quotient);
          state_d = ST_MH;
        end
      end
      ST_MH: begin
        mul_a   = w_q[QUO_W-1:WLO_W];
        mul_b   = hv;
        state_d = ST_ML;
      end
      ST_ML: begin
        num_d   = num_q + (NUM_W'(prod_q) << WLO_W);
        mul_a   = MUL_A_W'(w_q[WLO_W-1:0]);
        mul_b   = hv;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        num_d = num_q + NUM_W'(prod_q);
        if (k_q == 2'd3) begin
          state_d = ST_FIN;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_CORN;
        end
      end
      ST_FIN: begin
        // The weighted mean is below 2^16, so the upper part of num is already
        // below den and only the 24 result bits need to be produced.
        div_req.start    = 1'b1;
        div_req.rem_init = num_q[NUM_W-1:NUM_LO_W];
        div_req.lo       = {num_q[NUM_LO_W-1:0], {(QUO_W - NUM_LO_W){1'b0}}};
        div_req.divisor  = den_q;
        div_req.count    = CNT_W'(OUT_W);
        state_d          = ST_FDIV;
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.quotient[OUT_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    step_q <= step_d;
    c0_q   <= c0_d;
    r0_q   <= r0_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    d2_q   <= d2_d;
    w_q    <= w_d;
    num_q  <= num_d;
    den_q  <= den_d;
    res_q  <= res_d;
    prod_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  gidw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gidw_ram #(
    .WIDTH (HGT_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.control_height),
    .raddr_i (ram_raddr),
    .rdata_o (hv)
  );

  `GIDW_ASSERT_NEXT(a_query_enters_step,
    in_i.valid && in_i.ready && in_i.operation == gidw_pkg::OP_QUERY,
    state_q == ST_STEP, "query did not start the step computation")
  `GIDW_ASSERT_NOW(a_idle_div_free, state_q == ST_IDLE, !div_rsp.busy,
    "divider busy while the sequencer is idle")
  `GIDW_ASSERT_NOW(a_step_nonzero, state_q == ST_BRK || state_q == ST_CORN,
    step_q != '0, "grid step is zero during bracketing")
  `GIDW_ASSERT_NEXT(a_result_offered, state_q == ST_DONE && (!out_valid_q || out_o.ready),
    out_valid_q && state_q == ST_IDLE, "finished result was not offered")

endmodule

`default_nettype wire
